// File: rtl/nwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwd_pkg
// Shared constants, types and field helpers for the neighbour weighted
// decay update block.
// ----------------------------------------------------------------------------
package nwd_pkg;

  localparam int FRAC_BITS      = 12;
  localparam int TIME_FRAC      = 16;
  localparam int NUM_CELL_TYPES = 3;
  localparam int FIELD_W        = 20;
  localparam int SUM_W          = 40;
  localparam int POS_W          = 32;
  localparam int DEG_W          = 17;
  localparam int REINF_W        = 32;
  localparam int TS_W           = 24;
  localparam int PACK_W         = FIELD_W * NUM_CELL_TYPES;
  localparam int R2_W           = 2 * FIELD_W + 2;
  localparam int ROOT_W         = R2_W / 2;
  localparam int W_W            = FRAC_BITS + 1;
  localparam int APB_AW         = 6;
  localparam int APB_DW         = 64;

  localparam logic [DEG_W-1:0] DEG_ONE = DEG_W'(1) << TIME_FRAC;
  localparam logic [W_W-1:0]   W_ONE   = W_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_TIME_STEP = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_CELL_RAD  = 3'd3,
    REG_DEG_RATE  = 3'd4,
    REG_DEP_RATE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               enable;
    logic [TS_W-1:0]    step_size;
    logic [FIELD_W-1:0] influence_radius;
    logic [PACK_W-1:0]  cell_radii;
    logic [PACK_W-1:0]  degrade_rates;
    logic [PACK_W-1:0]  deposit_rates;
  } nwd_cfg_t;

  // One classified neighbour, as queued between the front and back parts.
  typedef struct packed {
    logic               en;
    logic               last;
    logic [FIELD_W-1:0] degrade_c;
    logic [FIELD_W-1:0] deposit_c;
    logic [DEG_W-1:0]   deg;
    logic [REINF_W-1:0] reinf;
    logic               mark;
  } nwd_entry_t;

  function automatic logic [FIELD_W-1:0] field_sel(input logic [PACK_W-1:0] packed_v,
                                                   input logic [1:0] t);
    logic [FIELD_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_CELL_TYPES; i++) begin
      if (t == 2'(i)) r = packed_v[i*FIELD_W +: FIELD_W];
    end
    return r;
  endfunction

  // Negative rates count as zero.
  function automatic logic [FIELD_W-1:0] rate_sel(input logic [PACK_W-1:0] packed_v,
                                                  input logic [1:0] t);
    logic [FIELD_W-1:0] v;
    v = field_sel(packed_v, t);
    return v[FIELD_W-1] ? '0 : v;
  endfunction

endpackage

// File: rtl/nwd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwd_in_if / nwd_out_if
// Valid/ready channels for neighbour items and node results.
// ----------------------------------------------------------------------------
interface nwd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] node_x;
  logic [31:0] node_y;
  logic [31:0] node_z;
  logic [16:0] node_degradation;
  logic [31:0] node_reinforcement;
  logic        node_marked;
  logic [31:0] cell_x;
  logic [31:0] cell_y;
  logic [31:0] cell_z;
  logic        cell_skip;
  logic [1:0]  cell_kind;
  logic        last_cell;

  modport source (output valid, node_x, node_y, node_z, node_degradation,
                  node_reinforcement, node_marked, cell_x, cell_y, cell_z,
                  cell_skip, cell_kind, last_cell, input ready);
  modport sink (input valid, node_x, node_y, node_z, node_degradation,
                node_reinforcement, node_marked, cell_x, cell_y, cell_z,
                cell_skip, cell_kind, last_cell, output ready);
endinterface

interface nwd_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] new_degradation;
  logic [31:0] new_reinforcement;
  logic        removal_mark;

  modport source (output valid, new_degradation, new_reinforcement, removal_mark,
                  input ready);
  modport sink (input valid, new_degradation, new_reinforcement, removal_mark,
                output ready);
endinterface

// File: rtl/nwd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwd_front
// Takes one neighbour item, finds its distance weight with an iterative
// square root and divider, and queues its two contributions.
// ----------------------------------------------------------------------------
module nwd_front
  import nwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  nwd_in_if.sink      item,
  input  nwd_cfg_t    cfg,
  output logic        push_valid,
  input  logic        push_ready,
  output nwd_entry_t  push_data
);

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_R2, F_SQRT, F_DIV, F_MUL, F_PUSH
  } state_t;

  state_t              state;
  logic [POS_W:0]      dx, dy, dz;
  logic                pre_ok, inrng;
  logic [1:0]          typ;
  logic [2*FIELD_W-1:0] sqx, sqy, sqz, rr;
  logic [R2_W-1:0]     x_sh;
  logic [ROOT_W:0]     rem;
  logic [ROOT_W-1:0]   root;
  logic [4:0]          cnt;
  logic [FIELD_W-1:0]  num_rem, den;
  logic [W_W-1:0]      w;
  nwd_entry_t          ent;

  logic [POS_W:0]      ddx, ddy, ddz;
  logic [R2_W-1:0]     r2;
  logic [ROOT_W+2:0]   rem_sh, trial;
  logic                sq_ge;
  logic [ROOT_W:0]     rem_next;
  logic [ROOT_W-1:0]   root_next;
  logic [FIELD_W:0]    div_sh;
  logic                div_ge;
  logic [FIELD_W-1:0]  cr, radius;
  logic [FIELD_W-1:0]  root_len;
  logic [W_W+FIELD_W-1:0] prod_d, prod_p;

  function automatic logic [POS_W:0] abs_diff(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[POS_W] ? -d : d;
  endfunction

  always_comb begin
    ddx       = abs_diff(item.cell_x, item.node_x);
    ddy       = abs_diff(item.cell_y, item.node_y);
    ddz       = abs_diff(item.cell_z, item.node_z);
    radius    = cfg.influence_radius;
    cr        = field_sel(cfg.cell_radii, typ);
    r2        = R2_W'(sqx) + R2_W'(sqy) + R2_W'(sqz);
    rem_sh    = {rem, x_sh[R2_W-1 -: 2]};
    trial     = {1'b0, root, 2'b01};
    sq_ge     = rem_sh >= trial;
    rem_next  = sq_ge ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
    root_next = {root[ROOT_W-2:0], sq_ge};
    root_len  = root_next[FIELD_W-1:0];
    div_sh    = {num_rem, 1'b0};
    div_ge    = div_sh >= {1'b0, den};
    prod_d    = w * rate_sel(cfg.degrade_rates, typ);
    prod_p    = w * rate_sel(cfg.deposit_rates, typ);
  end

  assign item.ready = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_data  = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (item.valid) begin
            dx        <= ddx;
            dy        <= ddy;
            dz        <= ddz;
            typ       <= item.cell_kind;
            pre_ok    <= cfg.enable && !item.cell_skip &&
                         (item.cell_kind < 2'(NUM_CELL_TYPES));
            ent.en    <= cfg.enable;
            ent.last  <= item.last_cell;
            ent.deg   <= item.node_degradation;
            ent.reinf <= item.node_reinforcement;
            ent.mark  <= item.node_marked;
            state     <= F_SQ;
          end
        end
        F_SQ: begin
          inrng <= (dx <= (POS_W+1)'(radius)) && (dy <= (POS_W+1)'(radius)) &&
                   (dz <= (POS_W+1)'(radius));
          sqx   <= dx[FIELD_W-1:0] * dx[FIELD_W-1:0];
          sqy   <= dy[FIELD_W-1:0] * dy[FIELD_W-1:0];
          sqz   <= dz[FIELD_W-1:0] * dz[FIELD_W-1:0];
          rr    <= radius * radius;
          state <= F_R2;
        end
        F_R2: begin
          if (pre_ok && inrng && (r2 <= R2_W'(rr))) begin
            x_sh  <= r2;
            rem   <= '0;
            root  <= '0;
            cnt   <= 5'(ROOT_W - 1);
            state <= F_SQRT;
          end else begin
            ent.degrade_c <= '0;
            ent.deposit_c <= '0;
            state         <= F_PUSH;
          end
        end
        F_SQRT: begin
          x_sh <= x_sh << 2;
          rem  <= rem_next;
          root <= root_next;
          cnt  <= cnt - 5'd1;
          if (cnt == '0) begin
            if ((root_len > cr) && (radius > cr)) begin
              num_rem <= radius - root_len;
              den     <= radius - cr;
              w       <= '0;
              cnt     <= 5'(FRAC_BITS - 1);
              state   <= F_DIV;
            end else begin
              w     <= W_ONE;
              state <= F_MUL;
            end
          end
        end
        F_DIV: begin
          num_rem <= div_ge ? FIELD_W'(div_sh - {1'b0, den}) : div_sh[FIELD_W-1:0];
          w       <= {w[W_W-2:0], div_ge};
          cnt     <= cnt - 5'd1;
          if (cnt == '0) state <= F_MUL;
        end
        F_MUL: begin
          ent.degrade_c <= prod_d[FRAC_BITS +: FIELD_W];
          ent.deposit_c <= prod_p[FRAC_BITS +: FIELD_W];
          state         <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/nwd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwd_queue
// Two-entry queue of classified neighbours between front and back.
// ----------------------------------------------------------------------------
module nwd_queue
  import nwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  nwd_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output nwd_entry_t pop_data
);

  nwd_entry_t slot [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slot[wptr] <= push_data;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: rtl/nwd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwd_back
// Accumulates contributions and, on the last neighbour, scales the sums by
// the time step and forms the node result; a disabled node passes unchanged.
// ----------------------------------------------------------------------------
module nwd_back
  import nwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  nwd_entry_t pop_data,
  input  nwd_cfg_t   cfg,
  nwd_out_if.source  result
);

  typedef enum logic [1:0] {B_ACC, B_MLO, B_MHI, B_FIN} state_t;

  localparam int HALF_W = SUM_W / 2;
  localparam int PP_W   = TS_W + HALF_W;
  localparam int INC_W  = 64 - FRAC_BITS;
  localparam int TOT_W  = INC_W + 1;

  state_t             state;
  logic [SUM_W-1:0]   dsum, psum;
  logic [PP_W-1:0]    plo_d, plo_p, phi_d, phi_p;
  logic [DEG_W-1:0]   deg;
  logic [REINF_W-1:0] reinf;
  logic               out_valid;
  logic [DEG_W-1:0]   out_deg;
  logic [REINF_W-1:0] out_reinf;
  logic               out_mark;

  logic [SUM_W-1:0]   dsum_next, psum_next;
  logic [63:0]        full_d, full_p;
  logic [TOT_W-1:0]   dtot, rtot;
  logic [DEG_W-1:0]   deg_fin;
  logic [REINF_W-1:0] reinf_fin;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [FIELD_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  always_comb begin
    dsum_next = sat_add(dsum, pop_data.degrade_c);
    psum_next = sat_add(psum, pop_data.deposit_c);
    full_d    = 64'(plo_d) + (64'(phi_d) << HALF_W);
    full_p    = 64'(plo_p) + (64'(phi_p) << HALF_W);
    dtot      = TOT_W'(deg) + TOT_W'(full_d[63:FRAC_BITS]);
    rtot      = TOT_W'(reinf) + TOT_W'(full_p[63:FRAC_BITS]);
    deg_fin   = (dtot > TOT_W'(DEG_ONE)) ? DEG_ONE : dtot[DEG_W-1:0];
    reinf_fin = (rtot > TOT_W'({REINF_W{1'b1}})) ? '1 : rtot[REINF_W-1:0];
  end

  assign pop_ready                = (state == B_ACC) && (!pop_data.last || !out_valid);
  assign result.valid             = out_valid;
  assign result.new_degradation   = out_deg;
  assign result.new_reinforcement = out_reinf;
  assign result.removal_mark      = out_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_ACC;
      dsum      <= '0;
      psum      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready) out_valid <= 1'b0;
      case (state)
        B_ACC: begin
          if (pop_valid && pop_ready) begin
            if (pop_data.last && pop_data.en) begin
              dsum  <= dsum_next;
              psum  <= psum_next;
              deg   <= pop_data.deg;
              reinf <= pop_data.reinf;
              state <= B_MLO;
            end else if (pop_data.last) begin
              out_deg   <= pop_data.deg;
              out_reinf <= pop_data.reinf;
              out_mark  <= pop_data.mark;
              out_valid <= 1'b1;
              dsum      <= '0;
              psum      <= '0;
            end else begin
              dsum <= dsum_next;
              psum <= psum_next;
            end
          end
        end
        B_MLO: begin
          plo_d <= cfg.step_size * dsum[HALF_W-1:0];
          plo_p <= cfg.step_size * psum[HALF_W-1:0];
          state <= B_MHI;
        end
        B_MHI: begin
          phi_d <= cfg.step_size * dsum[SUM_W-1:HALF_W];
          phi_p <= cfg.step_size * psum[SUM_W-1:HALF_W];
          state <= B_FIN;
        end
        B_FIN: begin
          out_deg   <= deg_fin;
          out_reinf <= reinf_fin;
          out_mark  <= (deg_fin == DEG_ONE) && (reinf_fin == '0);
          out_valid <= 1'b1;
          dsum      <= '0;
          psum      <= '0;
          state     <= B_ACC;
        end
        default: state <= B_ACC;
      endcase
    end
  end

endmodule

// File: rtl/neighbour_weighted_decay_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_weighted_decay_update
// Accumulates distance-weighted degradation and deposition from neighbour
// cells and updates one node's degradation, reinforcement and removal mark.
// ----------------------------------------------------------------------------
// Each transfer on the item channel pairs a node with one neighbour cell; the
// transfer marked last_cell closes the node and yields one transfer on the
// result channel. The front part handles one item at a time: a neighbour that
// is skipped, out of range or arrives while the block is disabled goes straight
// to the push, one inside the cell radius takes 21 square root steps, and one
// in the falloff band takes 21 square root steps plus 12 divide steps.
// A two-entry queue lets the front keep working while the back part finishes
// a node with the time-step scaling in its B_MLO, B_MHI and B_FIN states.
// Registers sit on an APB port at byte address 8*i with 64-bit data; they
// may only be written while no node is in flight.
// ----------------------------------------------------------------------------
module neighbour_weighted_decay_update
  import nwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  nwd_in_if.sink            item,
  nwd_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  nwd_cfg_t   cfg;
  cfg_reg_t   reg_sel;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  nwd_entry_t push_data, pop_data;

  // Register index sits above the 8-byte lane bits.
  assign reg_sel = cfg_reg_t'(paddr[APB_AW-1:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_ENABLE:    cfg.enable           <= pwdata[0];
        REG_TIME_STEP: cfg.step_size        <= pwdata[TS_W-1:0];
        REG_RADIUS:    cfg.influence_radius <= pwdata[FIELD_W-1:0];
        REG_CELL_RAD:  cfg.cell_radii       <= pwdata[PACK_W-1:0];
        REG_DEG_RATE:  cfg.degrade_rates    <= pwdata[PACK_W-1:0];
        REG_DEP_RATE:  cfg.deposit_rates    <= pwdata[PACK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENABLE:    prdata = APB_DW'(cfg.enable);
      REG_TIME_STEP: prdata = APB_DW'(cfg.step_size);
      REG_RADIUS:    prdata = APB_DW'(cfg.influence_radius);
      REG_CELL_RAD:  prdata = APB_DW'(cfg.cell_radii);
      REG_DEG_RATE:  prdata = APB_DW'(cfg.degrade_rates);
      REG_DEP_RATE:  prdata = APB_DW'(cfg.deposit_rates);
      default:       prdata = '0;
    endcase
  end

  // Front: distance, square root, weight division and rate scaling.
  nwd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  nwd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: saturating sums and the per-node update.
  nwd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

// File: rtl/nwd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwd_assert
// Port-level checks on the item and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module nwd_assert (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [16:0] res_deg,
  input logic [31:0] res_reinf,
  input logic        res_mark
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_deg) && $stable(res_reinf) && $stable(res_mark))
    else $error("result payload changed while stalled");

  // The front handles one item at a time, so it is busy right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item channel ready right after a transfer");

endmodule

bind neighbour_weighted_decay_update nwd_assert u_nwd_assert (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_deg    (result.new_degradation),
  .res_reinf  (result.new_reinforcement),
  .res_mark   (result.removal_mark)
);
